/* sv/sfgr_pkg.sv */
package sfgr_pkg;

    // Item kinds on the input channel.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Register reset value, silence count ceiling and width of the slot number output.
    localparam logic [7:0] GAP_TICKS_RESET = 8'd4;
    localparam logic [7:0] SILENCE_MAX     = 8'hFF;
    localparam int         POS_W           = 3;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SEND
    } sfgr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_byte;
        logic tick;
        logic fetch;
        logic next_slot;
        logic clear_store;
    } sfgr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gap_hit;
        logic pending;
        logic last_slot;
    } sfgr_status_t;

endpackage

/* sv/serial_frame_gap_receiver_unit.sv */
// Serial frame gap receiver. Received bytes (func = 0) are written into a store of
// FRAME_BYTES slots in arrival order, wrapping onto the oldest slot; timer ticks (func = 1)
// count line silence, and when the count reaches gap_ticks the frame ends. If bytes arrived
// since the last frame end, every slot is then sent out in slot order with last_byte set on
// the final word, and the store reads as zero afterwards. Byte and tick words are taken one
// per clock. A tick that ends a frame is followed by the output of every slot in two steps
// (the registered read of the frame store, then the output word), held while the consumer
// holds out_ready low; no input word is taken during that time. gap_ticks is written via
// cfg_we/cfg_wdata, by the user only while idle; the block itself does not enforce it.
module serial_frame_gap_receiver_unit #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  frame_byte,
    output logic [sfgr_pkg::POS_W-1:0]  byte_position,
    output logic                        last_byte,
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_wdata
);
    import sfgr_pkg::*;

    sfgr_cmd_t    cmd;
    sfgr_status_t status;

    // Sequencer.
    sfgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Frame store, counters and output word.
    sfgr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx_byte),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_byte     (last_byte)
    );

    // Input is never taken while a frame is being sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted during frame output");

    // After the final word of a frame the block is ready for input again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte) |=> (in_ready && !out_valid))
        else $error("block not idle after final frame word");

    // Slots follow each other: the word after an accepted one is the next slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_byte) |=> ##1
        (out_valid && (byte_position == POS_W'($past(byte_position, 2) + POS_W'(1)))))
        else $error("frame slots out of order");

    // A frame only starts from a tick word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (func == FUNC_BYTE)) |=> in_ready)
        else $error("byte word started frame output");

endmodule

/* sv/sfgr_datapath.sv */
module sfgr_datapath #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfgr_pkg::sfgr_cmd_t          cmd,
    output sfgr_pkg::sfgr_status_t       status,
    input  logic [7:0]                   rx_byte,
    input  logic                         cfg_we,
    input  logic [7:0]                   cfg_wdata,
    output logic [7:0]                   frame_byte,
    output logic [sfgr_pkg::POS_W-1:0]   byte_position,
    output logic                         last_byte
);
    import sfgr_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    logic [7:0]             mem [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] valid_reg;
    logic [FRAME_BYTES-1:0] valid_next;
    logic [IDX_W-1:0]       wr_idx_reg;
    logic [IDX_W-1:0]       wr_idx_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       rd_idx_next;
    logic [7:0]             silence_reg;
    logic [7:0]             silence_next;
    logic [7:0]             silence_inc;
    logic                   pending_reg;
    logic                   pending_next;
    logic [7:0]             gap_ticks_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_W+POS_W-1:0] pos_ext;

    // Saturating silence count and the end-of-gap test.
    assign silence_inc = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 8'd1;

    always_comb
    begin
        status.gap_hit   = (silence_inc >= gap_ticks_reg);
        status.pending   = pending_reg;
        status.last_slot = (rd_idx_reg == LAST_IDX);
    end

    // Next values of the control registers.
    always_comb
    begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        silence_next = silence_reg;
        pending_next = pending_reg;
        valid_next   = valid_reg;
        if (cmd.store_byte)
        begin
            wr_idx_next  = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + IDX_W'(1);
            silence_next = 8'd0;
            pending_next = 1'b1;
            valid_next[wr_idx_reg] = 1'b1;
        end
        if (cmd.tick)
        begin
            if (status.gap_hit)
            begin
                silence_next = 8'd0;
                wr_idx_next  = '0;
                pending_next = 1'b0;
            end
            else
            begin
                silence_next = silence_inc;
            end
        end
        if (cmd.next_slot)
        begin
            rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + IDX_W'(1);
        end
        if (cmd.clear_store)
        begin
            valid_next = '0;
        end
    end

    // Control registers, including the per-slot valid bits that stand for a zeroed store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            silence_reg   <= 8'd0;
            pending_reg   <= 1'b0;
            valid_reg     <= '0;
            gap_ticks_reg <= GAP_TICKS_RESET;
        end
        else
        begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            silence_reg <= silence_next;
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
            if (cfg_we)
            begin
                gap_ticks_reg <= cfg_wdata;
            end
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            mem[wr_idx_reg] <= rx_byte;
        end
        if (cmd.fetch)
        begin
            rd_data_reg  <= mem[rd_idx_reg];
            rd_valid_reg <= valid_reg[rd_idx_reg];
        end
    end

    // Output word: a slot that was never written since the last frame reads as zero.
    assign pos_ext       = {{POS_W{1'b0}}, rd_idx_reg};
    assign frame_byte    = rd_valid_reg ? rd_data_reg : 8'd0;
    assign byte_position = pos_ext[POS_W-1:0];
    assign last_byte     = status.last_slot;

endmodule

/* sv/sfgr_ctrl.sv */
module sfgr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  sfgr_pkg::sfgr_status_t  status,
    output sfgr_pkg::sfgr_cmd_t     cmd
);
    import sfgr_pkg::*;

    sfgr_state_t state_reg;
    sfgr_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (func == FUNC_TICK) && status.gap_hit && status.pending)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    state_next = status.last_slot ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.store_byte = in_valid && (func == FUNC_BYTE);
                cmd.tick       = in_valid && (func == FUNC_TICK);
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            S_SEND:
            begin
                out_valid       = 1'b1;
                cmd.next_slot   = out_ready;
                cmd.clear_store = out_ready && status.last_slot;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
